/* rtl/thsc_pkg.sv */
// shared types, constants and arithmetic helpers for the sensor compensation pipeline
package thsc_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_TEMP_COEF  = 3'd0,
		REG_HUM_ONE    = 3'd1,
		REG_HUM_TWO    = 3'd2,
		REG_HUM_THREE  = 3'd3,
		REG_HUM_FOUR   = 3'd4,
		REG_HUM_FIVE   = 3'd5,
		REG_HUM_SIX    = 3'd6
	} cfg_reg_t;

	localparam int unsigned CFG_W = 48;

	localparam logic [31:0] FINE_OFS      = 32'd76800;
	localparam logic [31:0] P_ROUND       = 32'd16384;
	localparam logic [31:0] R_OFS         = 32'd32768;
	localparam logic [31:0] Q_OFS         = 32'd2097152;
	localparam logic [31:0] Q_ROUND       = 32'd8192;
	localparam logic [31:0] HUM_MAX       = 32'd419430400;
	localparam logic [31:0] T_ROUND       = 32'd128;
	localparam logic [16:0] HUM_Q10_MAX   = 17'd102400;

	// temperature half of the pipeline handed to the humidity half
	typedef struct packed {
		logic        valid;
		logic [31:0] temp;
		logic [31:0] fine;
		logic [31:0] x;
		logic [15:0] raw_hum;
	} temp_res_t;

	// results that ride along the humidity stages
	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] fine;
	} side_t;

	// arithmetic shift right on a 32-bit two's complement word
	function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned sh);
		return 32'($unsigned($signed(x) >>> sh));
	endfunction

	// low 32 bits of a product
	function automatic logic [31:0] mulw(input logic [31:0] a, input logic [31:0] b);
		return a * b;
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sx8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

	// temperature in centidegrees from the fine value
	function automatic logic [31:0] centi(input logic [31:0] fine);
		return asr((fine << 2) + fine + T_ROUND, 8);
	endfunction

endpackage

/* rtl/thsc_temp.sv */
// temperature compensation stages one to four
module thsc_temp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [19:0]         raw_temperature,
	input  logic [15:0]         raw_humidity,
	input  logic [47:0]         temp_coefficients,
	output thsc_pkg::temp_res_t res
);
	import thsc_pkg::*;

	logic [31:0] t1, t2, t3, u, d;
	logic        v_s1, v_s2, v_s3, v_s4;
	logic [31:0] ma_s1, md_s1;
	logic [15:0] hum_s1, hum_s2, hum_s3, hum_s4;
	logic [31:0] a_s2, mb_s2;
	logic [31:0] fine_s3;
	logic [31:0] temp_s4, fine_s4, x_s4;

	assign t1 = {16'b0, temp_coefficients[15:0]};
	assign t2 = sx16(temp_coefficients[31:16]);
	assign t3 = sx16(temp_coefficients[47:32]);

	assign u = {15'b0, raw_temperature[19:3]} - {15'b0, temp_coefficients[15:0], 1'b0};
	assign d = {16'b0, raw_temperature[19:4]} - t1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1   <= mulw(u, t2);
			md_s1   <= mulw(d, d);
			hum_s1  <= raw_humidity;
			a_s2    <= asr(ma_s1, 11);
			mb_s2   <= mulw(asr(md_s1, 12), t3);
			hum_s2  <= hum_s1;
			fine_s3 <= a_s2 + asr(mb_s2, 14);
			hum_s3  <= hum_s2;
			temp_s4 <= centi(fine_s3);
			fine_s4 <= fine_s3;
			x_s4    <= fine_s3 - FINE_OFS;
			hum_s4  <= hum_s3;
		end
	end

	assign res = '{valid: v_s4, temp: temp_s4, fine: fine_s4, x: x_s4, raw_hum: hum_s4};

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> x_s4 + FINE_OFS == fine_s4)
		else $error("fine offset lost between stages");

	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(en) |-> $stable(v_s4) && $stable(fine_s4))
		else $error("temperature stages moved while frozen");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> temp_s4 == centi(fine_s4))
		else $error("centidegree value does not follow fine value");

endmodule

/* rtl/thsc_hum.sv */
// humidity compensation stages five to thirteen, ending in the output register
module thsc_hum (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  thsc_pkg::temp_res_t tin,
	input  logic [7:0]          hum_coef_one,
	input  logic [15:0]         hum_coef_two,
	input  logic [7:0]          hum_coef_three,
	input  logic [15:0]         hum_coef_four,
	input  logic [15:0]         hum_coef_five,
	input  logic [7:0]          hum_coef_six,
	output logic                out_valid,
	output logic signed [31:0]  temperature_centi,
	output logic signed [31:0]  fine_temperature,
	output logic [16:0]         humidity_q10
);
	import thsc_pkg::*;

	logic [31:0] h1, h2, h3, h4, h5, h6;
	logic        v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	side_t       sd_s5, sd_s6, sd_s7, sd_s8, sd_s9, sd_s10, sd_s11, sd_s12;
	logic [15:0] hum_s5;
	logic [31:0] mh5_s5, mq_s5, mr_s5;
	logic [31:0] p_s6, q_s6, r_s6;
	logic [31:0] p_s7, mqr_s7;
	logic [31:0] p_s8, mq2_s8;
	logic [31:0] p_s9, q3_s9;
	logic [31:0] x_s10, x_s11, x_s12;
	logic [31:0] ma_s11, mh1_s12;
	logic [31:0] acc;
	logic [16:0] hum_out;

	assign h1 = {24'b0, hum_coef_one};
	assign h2 = sx16(hum_coef_two);
	assign h3 = {24'b0, hum_coef_three};
	assign h4 = sx16(hum_coef_four);
	assign h5 = sx16(hum_coef_five);
	assign h6 = sx8(hum_coef_six);

	// final subtract and clamp to 0 .. 100 percent
	always_comb begin
		acc = x_s12 - asr(mh1_s12, 4);
		if (acc[31]) begin
			hum_out = '0;
		end else if (acc > HUM_MAX) begin
			hum_out = HUM_Q10_MAX;
		end else begin
			hum_out = acc[28:12];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			v_s9      <= 1'b0;
			v_s10     <= 1'b0;
			v_s11     <= 1'b0;
			v_s12     <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s5      <= tin.valid;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			v_s8      <= v_s7;
			v_s9      <= v_s8;
			v_s10     <= v_s9;
			v_s11     <= v_s10;
			v_s12     <= v_s11;
			out_valid <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s5  <= '{temp: tin.temp, fine: tin.fine};
			hum_s5 <= tin.raw_hum;
			mh5_s5 <= mulw(h5, tin.x);
			mq_s5  <= mulw(tin.x, h6);
			mr_s5  <= mulw(tin.x, h3);

			sd_s6 <= sd_s5;
			p_s6  <= asr({2'b0, hum_s5, 14'b0} - (h4 << 20) - mh5_s5
				+ P_ROUND, 15);
			q_s6  <= asr(mq_s5, 10);
			r_s6  <= asr(mr_s5, 11) + R_OFS;

			sd_s7  <= sd_s6;
			p_s7   <= p_s6;
			mqr_s7 <= mulw(q_s6, r_s6);

			sd_s8  <= sd_s7;
			p_s8   <= p_s7;
			mq2_s8 <= mulw(asr(mqr_s7, 10) + Q_OFS, h2);

			sd_s9 <= sd_s8;
			p_s9  <= p_s8;
			q3_s9 <= asr(mq2_s8 + Q_ROUND, 14);

			sd_s10 <= sd_s9;
			x_s10  <= mulw(p_s9, q3_s9);

			sd_s11 <= sd_s10;
			x_s11  <= x_s10;
			ma_s11 <= mulw(asr(x_s10, 15), asr(x_s10, 15));

			sd_s12  <= sd_s11;
			x_s12   <= x_s11;
			mh1_s12 <= mulw(asr(ma_s11, 7), h1);

			temperature_centi <= $signed(sd_s12.temp);
			fine_temperature  <= $signed(sd_s12.fine);
			humidity_q10      <= hum_out;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> humidity_q10 <= HUM_Q10_MAX)
		else $error("humidity above full scale");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s12 && acc[31] && en |=> humidity_q10 == '0)
		else $error("negative humidity not clamped");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $unsigned(temperature_centi) == centi($unsigned(fine_temperature)))
		else $error("temperature and fine value split apart");

endmodule

/* rtl/temp_humidity_sensor_compensation.sv */
// top level: configuration registers, stall control and the two compensation halves
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  input    | in_valid / in_stall       | raw_temperature[19:0], raw_humidity[15:0]
//  output   | out_valid / out_stall     | temperature_centi, fine_temperature, humidity_q10
//  config   | cfg_write, cfg_index[2:0] | cfg_data[47:0]
//
// one item per cycle while the pipeline is not frozen; the work runs through a chain of 32-bit multiply stages
// the whole pipeline, output register included, advances together; it freezes only while
// a result sits in the output register and out_stall is high, and in_stall follows that
// reset clears the valid bits and the calibration registers; no clearing pass is needed
module temp_humidity_sensor_compensation (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [19:0]                raw_temperature,
	input  logic [15:0]                raw_humidity,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [31:0]         temperature_centi,
	output logic signed [31:0]         fine_temperature,
	output logic [16:0]                humidity_q10,
	input  logic                       cfg_write,
	input  logic [2:0]                 cfg_index,
	input  logic [thsc_pkg::CFG_W-1:0] cfg_data
);
	import thsc_pkg::*;

	logic        en;
	temp_res_t   tres;
	logic [47:0] temp_coef_q;
	logic [7:0]  h1_q, h3_q, h6_q;
	logic [15:0] h2_q, h4_q, h5_q;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coef_q <= '0;
			h1_q        <= '0;
			h2_q        <= '0;
			h3_q        <= '0;
			h4_q        <= '0;
			h5_q        <= '0;
			h6_q        <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TEMP_COEF: temp_coef_q <= cfg_data[47:0];
				REG_HUM_ONE:   h1_q        <= cfg_data[7:0];
				REG_HUM_TWO:   h2_q        <= cfg_data[15:0];
				REG_HUM_THREE: h3_q        <= cfg_data[7:0];
				REG_HUM_FOUR:  h4_q        <= cfg_data[15:0];
				REG_HUM_FIVE:  h5_q        <= cfg_data[15:0];
				REG_HUM_SIX:   h6_q        <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	thsc_temp u_temp (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (en),
		.in_valid          (in_valid),
		.raw_temperature   (raw_temperature),
		.raw_humidity      (raw_humidity),
		.temp_coefficients (temp_coef_q),
		.res               (tres)
	);

	thsc_hum u_hum (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (en),
		.tin               (tres),
		.hum_coef_one      (h1_q),
		.hum_coef_two      (h2_q),
		.hum_coef_three    (h3_q),
		.hum_coef_four     (h4_q),
		.hum_coef_five     (h5_q),
		.hum_coef_six      (h6_q),
		.out_valid         (out_valid),
		.temperature_centi (temperature_centi),
		.fine_temperature  (fine_temperature),
		.humidity_q10      (humidity_q10)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input held off with nothing blocking the output");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(tres))
		else $error("pipeline moved while the output was blocked");

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write && cfg_index == REG_HUM_SIX |=> h6_q == $past(cfg_data[7:0]))
		else $error("calibration write lost");

endmodule
